// ===== design/ksa_pkg.sv =====
// Package: types, constants and the scancode table of the keyboard translator.
`timescale 1ns / 1ps
package ksa_pkg;

    localparam logic [7:0] PFX_EXT     = 8'hE0;
    localparam logic [7:0] PFX_REL     = 8'hF0;
    localparam logic [7:0] EXT_BIT     = 8'h80;
    localparam logic [7:0] KEY_CTRL    = 8'h14;
    localparam logic [7:0] KEY_SHIFT_L = 8'h12;
    localparam logic [7:0] KEY_SHIFT_R = 8'h59;
    localparam logic [7:0] KEY_CAPS    = 8'h58;

    localparam logic [6:0] CHAR_ESC    = 7'h1B;
    localparam logic [6:0] CHAR_BS     = 7'h08;
    localparam logic [6:0] CHAR_TAB    = 7'h09;
    localparam logic [6:0] CHAR_LF     = 7'h0A;
    localparam logic [6:0] CASE_BIT    = 7'h20;
    localparam logic [6:0] CTRL_MASK   = 7'h1F;
    localparam logic [2:0] LED_CAPS    = 3'b100;

    typedef enum logic {
        KIND_CHAR = 1'b0,
        KIND_LED  = 1'b1
    } kind_t;

    typedef struct packed {
        logic shift_held;
        logic ctrl_held;
        logic caps_on;
        logic extended_pending;
        logic release_pending;
        logic skip_acknowledge;
    } kbd_state_t;

    localparam int STATE_W = $bits(kbd_state_t);

    typedef struct packed {
        kind_t      out_kind;
        logic [6:0] char_code;
        logic [2:0] led_bits;
    } kbd_result_t;

    typedef struct packed {
        logic        has_result;
        kbd_result_t result;
    } kbd_step_t;

    // Scancode set 2 to ASCII; anything not listed, and the Esc key, is Esc.
    function automatic logic [6:0] key_char(input logic [7:0] code, input logic shifted);
        logic [6:0] c;
        c = CHAR_ESC;
        case (code)
            8'h0E: c = shifted ? 7'(8'h7E) : 7'(8'h27);
            8'h16: c = shifted ? 7'(8'h21) : 7'(8'h31);
            8'h1E: c = shifted ? 7'(8'h40) : 7'(8'h32);
            8'h26: c = shifted ? 7'(8'h23) : 7'(8'h33);
            8'h25: c = shifted ? 7'(8'h24) : 7'(8'h34);
            8'h2E: c = shifted ? 7'(8'h25) : 7'(8'h35);
            8'h36: c = shifted ? 7'(8'h5E) : 7'(8'h36);
            8'h3D: c = shifted ? 7'(8'h26) : 7'(8'h37);
            8'h3E: c = shifted ? 7'(8'h2A) : 7'(8'h38);
            8'h46: c = shifted ? 7'(8'h28) : 7'(8'h39);
            8'h45: c = shifted ? 7'(8'h29) : 7'(8'h30);
            8'h4E: c = shifted ? 7'(8'h5F) : 7'(8'h2D);
            8'h55: c = shifted ? 7'(8'h2B) : 7'(8'h3D);
            8'h61: c = shifted ? 7'(8'h7C) : 7'(8'h5C);
            8'h66: c = CHAR_BS;
            8'h0D: c = CHAR_TAB;
            8'h15: c = shifted ? 7'(8'h51) : 7'(8'h71);
            8'h1D: c = shifted ? 7'(8'h57) : 7'(8'h77);
            8'h24: c = shifted ? 7'(8'h45) : 7'(8'h65);
            8'h2D: c = shifted ? 7'(8'h52) : 7'(8'h72);
            8'h2C: c = shifted ? 7'(8'h54) : 7'(8'h74);
            8'h35: c = shifted ? 7'(8'h59) : 7'(8'h79);
            8'h3C: c = shifted ? 7'(8'h55) : 7'(8'h75);
            8'h43: c = shifted ? 7'(8'h49) : 7'(8'h69);
            8'h44: c = shifted ? 7'(8'h4F) : 7'(8'h6F);
            8'h4D: c = shifted ? 7'(8'h50) : 7'(8'h70);
            8'h5B: c = shifted ? 7'(8'h7B) : 7'(8'h5B);
            8'h5D: c = shifted ? 7'(8'h7D) : 7'(8'h5D);
            8'h1C: c = shifted ? 7'(8'h41) : 7'(8'h61);
            8'h1B: c = shifted ? 7'(8'h53) : 7'(8'h73);
            8'h23: c = shifted ? 7'(8'h44) : 7'(8'h64);
            8'h2B: c = shifted ? 7'(8'h46) : 7'(8'h66);
            8'h34: c = shifted ? 7'(8'h47) : 7'(8'h67);
            8'h33: c = shifted ? 7'(8'h48) : 7'(8'h68);
            8'h3B: c = shifted ? 7'(8'h4A) : 7'(8'h6A);
            8'h42: c = shifted ? 7'(8'h4B) : 7'(8'h6B);
            8'h4B: c = shifted ? 7'(8'h4C) : 7'(8'h6C);
            8'h4C: c = shifted ? 7'(8'h3A) : 7'(8'h3B);
            8'h52: c = shifted ? 7'(8'h22) : 7'(8'h27);
            8'h1A: c = shifted ? 7'(8'h5A) : 7'(8'h7A);
            8'h22: c = shifted ? 7'(8'h58) : 7'(8'h78);
            8'h21: c = shifted ? 7'(8'h43) : 7'(8'h63);
            8'h2A: c = shifted ? 7'(8'h56) : 7'(8'h76);
            8'h32: c = shifted ? 7'(8'h42) : 7'(8'h62);
            8'h31: c = shifted ? 7'(8'h4E) : 7'(8'h6E);
            8'h3A: c = shifted ? 7'(8'h4D) : 7'(8'h6D);
            8'h41: c = shifted ? 7'(8'h3C) : 7'(8'h2C);
            8'h49: c = shifted ? 7'(8'h3E) : 7'(8'h2E);
            8'h51: c = shifted ? 7'(8'h3F) : 7'(8'h2F);
            8'h29: c = 7'(8'h20);
            8'h5A: c = CHAR_LF;
            // keypad: same in both sets
            8'h70: c = 7'(8'h30);
            8'h71: c = 7'(8'h2E);
            8'h69: c = 7'(8'h31);
            8'h72: c = 7'(8'h32);
            8'h7A: c = 7'(8'h33);
            8'h6B: c = 7'(8'h34);
            8'h73: c = 7'(8'h35);
            8'h74: c = 7'(8'h36);
            8'h6C: c = 7'(8'h37);
            8'h75: c = 7'(8'h38);
            8'h7D: c = 7'(8'h39);
            8'hDA: c = CHAR_LF;
            8'hCA: c = 7'(8'h2F);
            8'h7C: c = 7'(8'h2A);
            8'h7B: c = 7'(8'h2D);
            8'h79: c = 7'(8'h2B);
            8'hEB: c = CHAR_BS;
            default: c = CHAR_ESC;
        endcase
        return c;
    endfunction

endpackage

// ===== design/ksa_if.sv =====
// Interfaces: scancode input channel and translated result channel.
`timescale 1ns / 1ps
interface ksa_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink (input valid, input scan_byte, output ready);
endinterface

interface ksa_out_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [6:0] char_code;
    logic [2:0] led_bits;

    modport source (output valid, output out_kind, output char_code, output led_bits,
                    input ready);
    modport sink (input valid, input out_kind, input char_code, input led_bits,
                  output ready);
endinterface

// ===== design/ksa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module ksa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ksa_decode.sv =====
// Per-byte decode: prefix and modifier tracking, table lookup, next flag state.
`timescale 1ns / 1ps
module ksa_decode (
    input  logic [7:0]          scan_byte,
    input  ksa_pkg::kbd_state_t cur,
    output ksa_pkg::kbd_state_t nxt,
    output ksa_pkg::kbd_step_t  step
);
    import ksa_pkg::*;

    logic [7:0] code;
    logic [6:0] raw_char;
    logic [6:0] fixed_char;
    logic       is_letter;
    logic       caps_next;

    assign code      = cur.extended_pending ? (scan_byte | EXT_BIT) : scan_byte;
    assign raw_char  = key_char(code, cur.shift_held);
    assign is_letter = ((raw_char >= 7'(8'h41)) && (raw_char <= 7'(8'h5A)))
                    || ((raw_char >= 7'(8'h61)) && (raw_char <= 7'(8'h7A)));
    assign caps_next = ~cur.caps_on;

    always_comb
    begin
        fixed_char = raw_char;
        if (is_letter)
        begin
            if (cur.caps_on)
            begin
                fixed_char = fixed_char ^ CASE_BIT;
            end
            if (cur.ctrl_held)
            begin
                fixed_char = fixed_char & CTRL_MASK;
            end
        end
    end

    always_comb
    begin
        nxt                       = cur;
        step.has_result           = 1'b0;
        step.result.out_kind      = KIND_CHAR;
        step.result.char_code     = '0;
        step.result.led_bits      = '0;
        if (cur.skip_acknowledge)
        begin
            nxt.skip_acknowledge = 1'b0;
        end
        else if (cur.release_pending)
        begin
            // break code: prefix bytes are taken as plain codes here
            nxt.release_pending = 1'b0;
            if ((scan_byte == KEY_SHIFT_L) || (scan_byte == KEY_SHIFT_R))
            begin
                nxt.shift_held = 1'b0;
            end
            else if (scan_byte == KEY_CTRL)
            begin
                nxt.ctrl_held = 1'b0;
            end
            else if (scan_byte == KEY_CAPS)
            begin
                nxt.caps_on          = caps_next;
                nxt.skip_acknowledge = 1'b1;
                step.has_result      = 1'b1;
                step.result.out_kind = KIND_LED;
                step.result.led_bits = caps_next ? LED_CAPS : 3'b000;
            end
        end
        else if (scan_byte == PFX_REL)
        begin
            nxt.extended_pending = 1'b0;
            nxt.release_pending  = 1'b1;
        end
        else if ((scan_byte == PFX_EXT) && !cur.extended_pending)
        begin
            nxt.extended_pending = 1'b1;
        end
        else
        begin
            nxt.extended_pending = 1'b0;
            if ((code == KEY_SHIFT_L) || (code == KEY_SHIFT_R))
            begin
                nxt.shift_held = 1'b1;
            end
            else if (code == KEY_CTRL)
            begin
                nxt.ctrl_held = 1'b1;
            end
            else if (code != KEY_CAPS)
            begin
                step.has_result       = 1'b1;
                step.result.char_code = fixed_char;
            end
        end
    end

endmodule

// ===== design/keyboard_scancode_to_ascii.sv =====
// Top level: PS/2 set 2 scancode to ASCII translator with flag state in RAM.
//
//  channel  dir  beat payload                       handshake
//  scan     in   scan_byte[7:0]                     valid/ready
//  chars    out  out_kind, char_code[6:0], led_bits valid/ready
//
// One byte per cycle sustained while result beats are taken. The flag word is
// read from the state RAM when a byte is taken and written back as that byte
// advances; a write that meets a read on the same edge is forwarded.
// After reset the RAM word counts as all zero until the first write-back.
// A stalled result beat holds the decode stage; bytes with no result still flow.
`timescale 1ns / 1ps
module keyboard_scancode_to_ascii (
    input logic clk,
    input logic rst_n,
    ksa_in_if.sink    scan,
    ksa_out_if.source chars
);
    import ksa_pkg::*;

    logic               take;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [7:0]         s1_byte_reg;
    logic               s1_advance;
    logic               fwd_hit_reg;
    kbd_state_t         fwd_data_reg;
    logic               rd_ok_reg;
    logic               ram_ok_reg;
    logic [STATE_W-1:0] ram_rdata;
    kbd_state_t         cur_state;
    kbd_state_t         new_state;
    kbd_step_t          step;
    logic               out_valid_reg;
    logic               out_valid_next;
    kbd_result_t        out_data_reg;

    ksa_ram #(
        .WIDTH(STATE_W),
        .DEPTH(1)
    ) u_state_ram (
        .clk  (clk),
        .we   (s1_advance),
        .waddr(1'b0),
        .wdata(new_state),
        .re   (take),
        .raddr(1'b0),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            cur_state = fwd_data_reg;
        end
        else if (rd_ok_reg)
        begin
            cur_state = kbd_state_t'(ram_rdata);
        end
        else
        begin
            cur_state = '0;
        end
    end

    ksa_decode u_decode (
        .scan_byte(s1_byte_reg),
        .cur      (cur_state),
        .nxt      (new_state),
        .step     (step)
    );

    assign s1_advance = s1_valid_reg
                     && (!step.has_result || !out_valid_reg || chars.ready);
    assign scan.ready = !s1_valid_reg || s1_advance;
    assign take       = scan.valid && scan.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance && step.has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (chars.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            rd_ok_reg     <= 1'b0;
            ram_ok_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_advance)
            begin
                ram_ok_reg <= 1'b1;
            end
            if (take)
            begin
                // RAM returns the old word when read and write share an edge
                fwd_hit_reg <= s1_advance;
                rd_ok_reg   <= ram_ok_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_byte_reg  <= scan.scan_byte;
            fwd_data_reg <= new_state;
        end
        if (s1_advance && step.has_result)
        begin
            out_data_reg <= step.result;
        end
    end

    assign chars.valid     = out_valid_reg;
    assign chars.out_kind  = out_data_reg.out_kind;
    assign chars.char_code = out_data_reg.char_code;
    assign chars.led_bits  = out_data_reg.led_bits;

endmodule
